// ===== rtl/ops_pkg.sv =====
`timescale 1ns / 1ps

package ops_pkg;

   localparam int NUM_BUTTONS = 12;
   localparam int BTN_W       = 4;
   localparam int TIMER_BITS  = 17;
   localparam int MASK_W      = 12;
   localparam int SECS_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;

   typedef logic [3:0] prog_type;

   localparam prog_type PRG_STOP  = 4'd0;
   localparam prog_type PRG_IDLE  = 4'd1;
   localparam prog_type PRG_WORK  = 4'd2;
   localparam prog_type PRG_AUX3  = 4'd3;
   localparam prog_type PRG_AUX4  = 4'd4;
   localparam prog_type PRG_FLUSH = 4'd5;
   localparam prog_type PRG_FILL  = 4'd6;

   localparam logic [3:0] LAMP_ONE   = 4'd1;
   localparam logic [3:0] LAMP_WORK  = 4'd3;
   localparam logic [3:0] LAMP_FLUSH = 4'd6;

   localparam logic [BTN_W-1:0] BTN_WORK = 4'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_MASK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TANK_ENABLE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_EMPTY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_FULL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLUSH_WAIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FLUSH_ON     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PERMEATE     = 3'd6;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

endpackage

// ===== rtl/osmosis_program_sequencer_unit.sv =====
`timescale 1ns / 1ps

// Reverse-osmosis program sequencer. Each beat on req_ is one poll (qualified
// presses, tank level, one-second tick) and yields exactly one beat on rsp_
// with the program, lit button, lamp code, last event, change pulse and held
// tank state. A poll is taken every cycle while req_tready is high and its
// result is written straight into the output register; the state update
// (button priority encoder, timer compare and program transition) ahead of
// it is combinational. req_tready only drops while a result waits in the
// output register and rsp_tready is low. Configuration writes on the csr_
// port take effect at the next clock edge.
module osmosis_program_sequencer_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // buttons_pressed[11:0], tank_full_level[12], second_tick[13], zero pad
   input  logic [ops_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // program_res[3:0], lit_button[7:4], light_code[11:8], last_event[15:12],
   // program_changed[16], tank_full[17], zero pad
   output logic [ops_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [ops_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ops_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ops_pkg::*;

   // configuration
   logic [MASK_W-1:0] mask_ff;
   logic              tank_en_ff;
   logic [SECS_W-1:0] wait_empty_ff, wait_full_ff, flush_wait_ff, flush_on_ff;
   logic [SECS_W-1:0] permeate_ff;

   // sequencer state
   prog_type              program_ff, program_in;
   logic [BTN_W-1:0]      lit_ff, lit_in;
   logic [3:0]            event_ff, event_in;
   logic [3:0]            light_ff, light_in;
   logic                  tank_ff, tank_in;
   logic                  tank_prev_ff, tank_prev_in;
   logic                  tank_known_ff, tank_known_in;
   prog_type              prev_prog_ff, prev_prog_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic                  changed_in;

   // output register
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   logic                    accept;
   logic [MASK_W-1:0]       pressed;
   logic                    level, tick;
   logic [NUM_BUTTONS-1:0]  cand;
   logic [BTN_W-1:0]        sel;
   logic                    found;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign pressed = req_tdata[MASK_W-1:0];
   assign level   = req_tdata[MASK_W];
   assign tick    = req_tdata[MASK_W+1];

   // candidate buttons: pressed, enabled, not lit, button 2 masked in flush
   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         cand[i] = pressed[i] && mask_ff[i] && (lit_ff != BTN_W'(i))
                   && !((program_ff == PRG_FLUSH) && (BTN_W'(i) == BTN_WORK));
      end
   end

   // lowest candidate wins
   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            sel   = BTN_W'(i);
            found = 1'b1;
         end
      end
   end

   always_comb begin
      logic rearm;
      logic track;
      program_in    = program_ff;
      lit_in        = lit_ff;
      event_in      = event_ff;
      light_in      = light_ff;
      tank_prev_in  = tank_prev_ff;
      tank_known_in = tank_known_ff;
      prev_prog_in  = prev_prog_ff;
      changed_in    = 1'b0;
      rearm         = 1'b0;
      track         = 1'b0;

      timer_in = timer_ff;
      if (tick && (timer_ff != TIMER_MAX)) timer_in = timer_ff + 1'b1;

      if (found) begin
         lit_in = sel;
         if (!((sel == BTN_WORK) && tank_ff)) begin
            program_in = sel;
            event_in   = sel;
            light_in   = sel + 1'b1;
            changed_in = 1'b1;
         end
      end

      tank_in = tank_en_ff ? level : tank_ff;

      case (program_in)
         PRG_IDLE, PRG_AUX3, PRG_AUX4, PRG_FLUSH, PRG_FILL: track = 1'b0;
         default: track = 1'b1;
      endcase

      // outside idle, aux, flush and fill, a change of level (or the first sample) restarts the timer
      if (track && (!tank_known_ff || (tank_prev_ff != tank_in))) begin
         tank_prev_in  = tank_in;
         tank_known_in = 1'b1;
         timer_in      = '0;
      end

      case (program_in)
         PRG_IDLE: ;
         PRG_WORK: begin
            if (tank_in && (timer_in > TIMER_BITS'(wait_full_ff))) begin
               program_in = PRG_FILL;
               event_in   = PRG_FILL;
               light_in   = LAMP_ONE;
               timer_in   = '0;
               changed_in = 1'b1;
            end else if (!tank_in && (timer_in > TIMER_BITS'(flush_wait_ff))) begin
               program_in = PRG_FLUSH;
               event_in   = PRG_FLUSH;
               light_in   = LAMP_FLUSH;
               timer_in   = '0;
               changed_in = 1'b1;
            end else begin
               rearm = 1'b1;
            end
         end
         PRG_AUX3, PRG_AUX4: rearm = 1'b1;
         PRG_FLUSH: begin
            if (timer_in > TIMER_BITS'(flush_on_ff)) begin
               if (event_in == PRG_FLUSH) begin
                  program_in = PRG_WORK;
                  event_in   = PRG_WORK;
                  light_in   = LAMP_WORK;
                  timer_in   = '0;
                  changed_in = 1'b1;
               end
            end else begin
               rearm = 1'b1;
            end
         end
         PRG_FILL: begin
            if (timer_in > TIMER_BITS'(permeate_ff)) begin
               program_in = PRG_STOP;
               event_in   = PRG_STOP;
               light_in   = LAMP_ONE;
               timer_in   = '0;
               changed_in = 1'b1;
            end else begin
               rearm = 1'b1;
            end
         end
         default: begin
            if (!tank_in && (timer_in > TIMER_BITS'(wait_empty_ff))) begin
               program_in = PRG_WORK;
               event_in   = PRG_WORK;
               light_in   = LAMP_WORK;
               timer_in   = '0;
               changed_in = 1'b1;
            end else begin
               rearm = 1'b1;
            end
         end
      endcase

      // restart the timer on the first waiting poll in a newly entered program
      if (rearm && (prev_prog_ff != program_in)) begin
         prev_prog_in = program_in;
         timer_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= '1;
         tank_en_ff    <= 1'b1;
         wait_empty_ff <= '0;
         wait_full_ff  <= '0;
         flush_wait_ff <= '0;
         flush_on_ff   <= '0;
         permeate_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BUTTON_MASK: mask_ff       <= csr_wdata[MASK_W-1:0];
            CSR_TANK_ENABLE: tank_en_ff    <= csr_wdata[0];
            CSR_WAIT_EMPTY:  wait_empty_ff <= csr_wdata[SECS_W-1:0];
            CSR_WAIT_FULL:   wait_full_ff  <= csr_wdata[SECS_W-1:0];
            CSR_FLUSH_WAIT:  flush_wait_ff <= csr_wdata[SECS_W-1:0];
            CSR_FLUSH_ON:    flush_on_ff   <= csr_wdata[SECS_W-1:0];
            CSR_PERMEATE:    permeate_ff   <= csr_wdata[SECS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         program_ff    <= PRG_STOP;
         lit_ff        <= '0;
         event_ff      <= PRG_STOP;
         light_ff      <= LAMP_ONE;
         tank_ff       <= 1'b0;
         tank_prev_ff  <= 1'b0;
         tank_known_ff <= 1'b0;
         prev_prog_ff  <= PRG_WORK;
         timer_ff      <= '0;
      end else if (accept) begin
         program_ff    <= program_in;
         lit_ff        <= lit_in;
         event_ff      <= event_in;
         light_ff      <= light_in;
         tank_ff       <= tank_in;
         tank_prev_ff  <= tank_prev_in;
         tank_known_ff <= tank_known_in;
         prev_prog_ff  <= prev_prog_in;
         timer_ff      <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (accept) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= {6'b0, tank_in, changed_in, event_in, light_in, lit_in,
                          program_in};
      end
   end

endmodule

// ===== sim/program_sequence_checker.sv =====
`timescale 1ns / 1ps

module program_sequence_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ops_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ops_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [ops_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ops_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             polls_outstanding
);
   import ops_pkg::*;

   // laid out so that bit 0 matches bit 0 of rsp_tdata
   typedef struct packed {
      logic       tank;
      logic       changed;
      logic [3:0] evt;
      logic [3:0] lamp;
      logic [3:0] lit;
      prog_type   prog;
   } poll_result_type;

   logic [MASK_W-1:0]     mask_q;
   logic                  sensor_on_q;
   logic [SECS_W-1:0]     wait_empty_q;
   logic [SECS_W-1:0]     wait_full_q;
   logic [SECS_W-1:0]     flush_wait_q;
   logic [SECS_W-1:0]     flush_on_q;
   logic [SECS_W-1:0]     fill_q;

   prog_type              prog_q;
   prog_type              prev_prog_q;
   logic [BTN_W-1:0]      lit_q;
   logic [3:0]            evt_q;
   logic [3:0]            lamp_q;
   logic                  tank_q;
   logic                  tank_prev_q;
   logic                  tank_known_q;
   logic [TIMER_BITS-1:0] elapsed_q;
   logic                  changed_now;

   poll_result_type       expected_q[$];
   int                    errors = 0;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   function automatic void enter_program(input prog_type prg, input logic [3:0] lamp);
      prog_q      = prg;
      evt_q       = prg;
      lamp_q      = lamp;
      elapsed_q   = '0;
      changed_now = 1'b1;
   endfunction

   function automatic void rearm_entry();
      if (prev_prog_q != prog_q) begin
         prev_prog_q = prog_q;
         elapsed_q   = '0;
      end
   endfunction

   // a first sample or a change of level restarts the timer
   function automatic void follow_level();
      if (!tank_known_q || tank_prev_q != tank_q) begin
         tank_prev_q  = tank_q;
         tank_known_q = 1'b1;
         elapsed_q    = '0;
      end
   endfunction

   function automatic poll_result_type next_poll_result(input logic [MASK_W-1:0] pressed,
                                                        input logic level, input logic tick);
      poll_result_type r;
      int              btn;
      changed_now = 1'b0;
      if (tick && elapsed_q != TIMER_MAX)
         elapsed_q++;

      // lowest usable press that is not already lit
      for (btn = 0; btn < NUM_BUTTONS; btn++) begin
         if (lit_q == BTN_W'(btn) || (prog_q == PRG_FLUSH && BTN_W'(btn) == BTN_WORK) ||
             !mask_q[btn] || !pressed[btn])
            continue;
         lit_q = BTN_W'(btn);
         if (!(BTN_W'(btn) == BTN_WORK && tank_q)) begin
            prog_q      = prog_type'(btn);
            evt_q       = 4'(btn);
            lamp_q      = 4'(btn + 1);
            changed_now = 1'b1;
         end
         break;
      end

      if (sensor_on_q)
         tank_q = level;

      case (prog_q)
         PRG_IDLE: ;
         PRG_WORK: begin
            follow_level();
            if (tank_q && elapsed_q > wait_full_q)
               enter_program(PRG_FILL, LAMP_ONE);
            else if (!tank_q && elapsed_q > flush_wait_q)
               enter_program(PRG_FLUSH, LAMP_FLUSH);
            else
               rearm_entry();
         end
         PRG_AUX3, PRG_AUX4: rearm_entry();
         PRG_FLUSH: begin
            if (elapsed_q > flush_on_q) begin
               if (evt_q == PRG_FLUSH)
                  enter_program(PRG_WORK, LAMP_WORK);
            end else begin
               rearm_entry();
            end
         end
         PRG_FILL: begin
            if (elapsed_q > fill_q)
               enter_program(PRG_STOP, LAMP_ONE);
            else
               rearm_entry();
         end
         default: begin
            follow_level();
            if (!tank_q && elapsed_q > wait_empty_q)
               enter_program(PRG_WORK, LAMP_WORK);
            else
               rearm_entry();
         end
      endcase

      r.prog    = prog_q;
      r.lit     = lit_q;
      r.lamp    = lamp_q;
      r.evt     = evt_q;
      r.changed = changed_now;
      r.tank    = tank_q;
      return r;
   endfunction

   always @(posedge clock) begin
      poll_result_type got;
      poll_result_type want;
      if (reset) begin
         mask_q       = '1;
         sensor_on_q  = 1'b1;
         wait_empty_q = '0;
         wait_full_q  = '0;
         flush_wait_q = '0;
         flush_on_q   = '0;
         fill_q       = '0;
         prog_q       = PRG_STOP;
         prev_prog_q  = PRG_WORK;
         lit_q        = '0;
         evt_q        = '0;
         lamp_q       = LAMP_ONE;
         tank_q       = 1'b0;
         tank_prev_q  = 1'b0;
         tank_known_q = 1'b0;
         elapsed_q    = '0;
         expected_q.delete();
      end else begin
         // the result leaving now belongs to an older poll than any taken now
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result beat with no poll pending");
            end else begin
               want = expected_q.pop_front();
               got  = rsp_tdata[$bits(poll_result_type)-1:0];
               check_field("program_res", got.prog, want.prog);
               check_field("lit_button", got.lit, want.lit);
               check_field("light_code", got.lamp, want.lamp);
               check_field("last_event", got.evt, want.evt);
               check_field("program_changed", got.changed, want.changed);
               check_field("tank_full", got.tank, want.tank);
            end
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(next_poll_result(req_tdata[MASK_W-1:0], req_tdata[MASK_W],
                                                  req_tdata[MASK_W+1]));
         if (csr_we) begin
            case (csr_index)
               CSR_BUTTON_MASK: mask_q       = csr_wdata[MASK_W-1:0];
               CSR_TANK_ENABLE: sensor_on_q  = csr_wdata[0];
               CSR_WAIT_EMPTY:  wait_empty_q = csr_wdata;
               CSR_WAIT_FULL:   wait_full_q  = csr_wdata;
               CSR_FLUSH_WAIT:  flush_wait_q = csr_wdata;
               CSR_FLUSH_ON:    flush_on_q   = csr_wdata;
               CSR_PERMEATE:    fill_q       = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatch_count    <= errors;
      polls_outstanding <= expected_q.size();
   end

endmodule

// ===== sim/osmosis_program_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps

module osmosis_program_sequencer_unit_tb;
   import ops_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    mismatch_count;
   int                    polls_outstanding;
   logic                  level_now;

   osmosis_program_sequencer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   program_sequence_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .polls_outstanding (polls_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: changing stall pattern, plus one long hold-off to back up the input
   initial begin
      int  stall_mode;
      int  mode_left;
      int  hold_left;
      int  beats;
      bit  held_once;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      beats      = 0;
      held_once  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            beats++;
         if (!held_once && beats >= 200) begin
            held_once = 1'b1;
            hold_left = 64;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_poll(input logic [MASK_W-1:0] buttons, input logic level,
                            input logic tick);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({tick, level, buttons});
      do @(posedge clock); while (!req_tready);
   endtask

   // level holds for stretches, ticks are frequent, presses are rare
   task automatic send_random_poll();
      logic [MASK_W-1:0] buttons;
      logic              tick;
      if ($urandom_range(0, 9) == 0)
         level_now = ~level_now;
      tick = ($urandom_range(0, 9) < 7);
      case ($urandom_range(0, 19))
         0, 1, 2: buttons = MASK_W'(1) << $urandom_range(0, NUM_BUTTONS - 1);
         3:       buttons = MASK_W'($urandom);
         default: buttons = '0;
      endcase
      send_poll(buttons, level_now, tick);
   endtask

   task automatic run_random_polls(input int count);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send_random_poll();
            sent++;
         end
         gap = $urandom_range(0, 5);
         if (gap > 0 && $urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // pause the sender until every result is back
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (polls_outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_settings(input logic [MASK_W-1:0] mask, input logic sensor_on,
                                   input logic [SECS_W-1:0] empty_s, input logic [SECS_W-1:0] full_s,
                                   input logic [SECS_W-1:0] fwait_s, input logic [SECS_W-1:0] fon_s,
                                   input logic [SECS_W-1:0] fill_s);
      write_csr(CSR_BUTTON_MASK, CSR_DATA_W'(mask));
      write_csr(CSR_TANK_ENABLE, CSR_DATA_W'(sensor_on));
      write_csr(CSR_WAIT_EMPTY, empty_s);
      write_csr(CSR_WAIT_FULL, full_s);
      write_csr(CSR_FLUSH_WAIT, fwait_s);
      write_csr(CSR_FLUSH_ON, fon_s);
      write_csr(CSR_PERMEATE, fill_s);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [SECS_W-1:0] short_wait(input int top);
      return SECS_W'($urandom_range(0, top));
   endfunction

   initial begin
      int phase;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_BUTTON_MASK;
      csr_wdata  = '0;
      level_now  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, all waits zero: walk every automatic change
      send_poll(12'h000, 1'b0, 1'b0);
      send_poll(12'h000, 1'b0, 1'b1);
      send_poll(12'h000, 1'b1, 1'b1);
      send_poll(12'h000, 1'b1, 1'b1);
      send_poll(12'h000, 1'b1, 1'b1);
      send_poll(12'h000, 1'b0, 1'b1);
      send_poll(12'h000, 1'b0, 1'b1);
      send_poll(12'h000, 1'b0, 1'b1);
      // button 2 while flushing, then button 2 with the tank full
      send_poll(12'h004, 1'b0, 1'b1);
      send_poll(12'h000, 1'b1, 1'b0);
      send_poll(12'h004, 1'b1, 1'b0);
      send_poll(12'hFFF, 1'b0, 1'b1);
      send_poll(12'h002, 1'b0, 1'b1);
      send_poll(12'h008, 1'b0, 1'b1);
      send_poll(12'h010, 1'b0, 1'b1);
      send_poll(12'h800, 1'b0, 1'b1);
      send_poll(12'h080, 1'b1, 1'b1);
      send_poll(12'h020, 1'b0, 1'b0);
      send_poll(12'h040, 1'b1, 1'b1);
      send_poll(12'h000, 1'b0, 1'b1);
      send_poll(12'h400, 1'b0, 1'b0);
      send_poll(12'hAAA, 1'b1, 1'b1);
      send_poll(12'h555, 1'b0, 1'b0);
      send_poll(12'h001, 1'b1, 1'b1);
      settle();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_settings(12'hFFF, 1'b1, short_wait(3), short_wait(3), short_wait(3),
                                short_wait(3), short_wait(3));
            1: program_settings(12'h000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000);
            2: program_settings(MASK_W'($urandom), 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF);
            3: program_settings(MASK_W'($urandom), 1'($urandom_range(0, 1)), short_wait(6),
                                short_wait(6), short_wait(6), short_wait(6), short_wait(6));
            4: program_settings(12'hFFF, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000);
            default: program_settings(MASK_W'($urandom) | 12'h024, 1'b1, short_wait(2),
                                      short_wait(8), short_wait(2), short_wait(4),
                                      short_wait(8));
         endcase
         run_random_polls(140);
         settle();
      end

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
